// ===== rtl/vwma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vwma_pkg;

	// Field widths of one bar and one result
	localparam int PRICE_W  = 24;
	localparam int VOLUME_W = 24;
	localparam int PROD_W   = PRICE_W + VOLUME_W;

	// Configuration port
	localparam int CFG_W    = 9;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd20;
	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	// Divider step counter
	localparam int DIV_CNT_W = $clog2(PRICE_W);

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [VOLUME_W-1:0] volume;
	} bar_t;

	typedef struct packed {
		logic [PRICE_W-1:0] average;
		logic               zero_volume;
	} avg_t;

	// Queue fill status seen by the front end
	typedef struct packed {
		logic full;
		logic almost_full;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_OUT
	} div_state_t;

endpackage

`default_nettype wire

// ===== rtl/vwma_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwma_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read of the slot being written returns the old entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/vwma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwma_front #(
	parameter int MAX_WINDOW = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                bar_valid,
	output logic                                     bar_ready,
	input  wire vwma_pkg::bar_t                      bar,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     win_len,
	input  wire logic                                restart,
	input  wire vwma_pkg::fifo_stat_t                q_stat,
	output logic                                     push,
	output logic [vwma_pkg::PROD_W+$clog2(MAX_WINDOW)-1:0]   psum,
	output logic [vwma_pkg::VOLUME_W+$clog2(MAX_WINDOW)-1:0] vsum
);

	import vwma_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW+1);
	localparam int PS_W  = PROD_W + AW;
	localparam int VS_W  = VOLUME_W + AW;
	localparam int ENT_W = PROD_W + VOLUME_W;

	logic [AW-1:0]       wp_q;
	logic [CNT_W-1:0]    fill_q;
	logic [PS_W-1:0]     psum_q;
	logic [VS_W-1:0]     vsum_q;

	logic                valid_s1;
	logic                sub_s1;
	logic                emit_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [VOLUME_W-1:0] vol_s1;

	logic                accept;
	logic                full_win;
	logic [CNT_W-1:0]    fill_inc;
	logic [CNT_W-1:0]    wp_ext;
	logic [AW-1:0]       old_addr;
	logic [AW-1:0]       wp_next;
	logic [PROD_W-1:0]   prod;
	logic [ENT_W-1:0]    old_ent;
	logic [PROD_W-1:0]   old_prod;
	logic [VOLUME_W-1:0] old_vol;
	logic [PS_W-1:0]     psum_next;
	logic [VS_W-1:0]     vsum_next;

	// hold off when the queue could not take this bar's result
	assign bar_ready = !(q_stat.full || (q_stat.almost_full && valid_s1 && emit_s1));
	assign accept    = bar_valid && bar_ready;

	assign full_win = (fill_q >= win_len);
	assign fill_inc = fill_q + 1'b1;
	assign prod     = PROD_W'(bar.price) * PROD_W'(bar.volume);

	// slot of the bar leaving the window, modulo the ring depth
	assign wp_ext   = CNT_W'(wp_q);
	assign old_addr = (wp_ext >= win_len) ? AW'(wp_ext - win_len)
	                                      : AW'(CNT_W'(MAX_WINDOW) - win_len + wp_ext);
	assign wp_next  = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;

	// ring of {price*volume, volume}
	vwma_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata ({prod, bar.volume}),
		.re    (accept),
		.raddr (old_addr),
		.rdata (old_ent)
	);

	assign old_prod = old_ent[ENT_W-1:VOLUME_W];
	assign old_vol  = old_ent[VOLUME_W-1:0];

	// window sums: drop the leaving bar, add the new one
	assign psum_next = psum_q - (sub_s1 ? PS_W'(old_prod) : '0) + PS_W'(prod_s1);
	assign vsum_next = vsum_q - (sub_s1 ? VS_W'(old_vol) : '0) + VS_W'(vol_s1);

	// pointer, fill count and first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (restart) begin
				fill_q <= '0;
			end else if (accept) begin
				wp_q <= wp_next;
				if (!full_win) begin
					fill_q <= fill_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sub_s1  <= full_win;
			emit_s1 <= full_win || (fill_inc == win_len);
			prod_s1 <= prod;
			vol_s1  <= bar.volume;
		end
	end

	// running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
			vsum_q <= '0;
		end else if (restart) begin
			psum_q <= '0;
			vsum_q <= '0;
		end else if (valid_s1) begin
			psum_q <= psum_next;
			vsum_q <= vsum_next;
		end
	end

	assign push = valid_s1 && emit_s1;
	assign psum = psum_next;
	assign vsum = vsum_next;

endmodule

`default_nettype wire

// ===== rtl/vwma_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwma_fifo #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic                  rvalid,
	output logic      [WIDTH-1:0] rdata,
	output vwma_pkg::fifo_stat_t  stat
);

	import vwma_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign do_pop = pop && (count_q != '0);

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= wdata;
		end
	end

	assign rvalid           = (count_q != '0);
	assign rdata            = slot_q[head_q];
	assign stat.full        = (count_q == CW'(DEPTH));
	assign stat.almost_full = (count_q >= CW'(DEPTH - 1));

endmodule

`default_nettype wire

// ===== rtl/vwma_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwma_divider #(
	parameter int MAX_WINDOW = 256
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           q_valid,
	input  wire logic [vwma_pkg::PROD_W+$clog2(MAX_WINDOW)-1:0]   psum,
	input  wire logic [vwma_pkg::VOLUME_W+$clog2(MAX_WINDOW)-1:0] vsum,
	output logic                                                q_pop,
	output logic                                                avg_valid,
	input  wire logic                                           avg_ready,
	output vwma_pkg::avg_t                                      avg
);

	import vwma_pkg::*;

	localparam int PS_W = PROD_W + $clog2(MAX_WINDOW);
	localparam int VS_W = VOLUME_W + $clog2(MAX_WINDOW);

	div_state_t           state_q;
	div_state_t           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VS_W-1:0]      rem_q;
	logic [VS_W-1:0]      den_q;
	logic [PRICE_W-1:0]   num_q;
	logic [PRICE_W-1:0]   quo_q;
	logic                 zero_q;

	logic [VS_W:0]        trial;
	logic                 take;
	logic                 vsum_zero;

	assign vsum_zero = (vsum == '0);

	// restoring step: one quotient bit a cycle
	assign trial = {rem_q, num_q[PRICE_W-1]};
	assign take  = (trial >= {1'b0, den_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (q_valid) begin
					state_d = vsum_zero ? DIV_OUT : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DIV_OUT;
				end
			end
			DIV_OUT: begin
				if (avg_ready) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = 1'b0;
		avg_valid = 1'b0;
		case (state_q)
			DIV_IDLE: q_pop     = q_valid;
			DIV_OUT:  avg_valid = 1'b1;
			default: begin
				q_pop     = 1'b0;
				avg_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath; the quotient never exceeds the largest price, so the
	// sum's bits above the price width start as the partial remainder
	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (q_valid) begin
					rem_q  <= VS_W'(psum >> PRICE_W);
					num_q  <= psum[PRICE_W-1:0];
					den_q  <= vsum;
					quo_q  <= '0;
					zero_q <= vsum_zero;
					cnt_q  <= DIV_CNT_W'(PRICE_W - 1);
				end
			end
			DIV_RUN: begin
				rem_q <= take ? VS_W'(trial - {1'b0, den_q}) : VS_W'(trial);
				num_q <= {num_q[PRICE_W-2:0], 1'b0};
				quo_q <= {quo_q[PRICE_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign avg.average     = quo_q;
	assign avg.zero_volume = zero_q;

endmodule

`default_nettype wire

// ===== rtl/volume_weighted_moving_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Volume weighted moving average over the last window_length bars (register
// at byte address 0, reset 20, 0 acts as 1, values above MAX_WINDOW clamp).
// Writing window_length restarts the window; a result follows every bar from
// the window_length-th new one on. While the queue has room, the front end
// takes one bar per cycle: it keeps price*volume and volume in a ring RAM
// and updates exact running sums in the cycle after the bar. Sums of finished
// windows wait in a QUEUE_DEPTH entry queue for a bit-serial divider, which
// loads the sums, runs 24 quotient steps (none for a zero volume sum), holds
// the result until taken and only then takes the next sum; so it sets the
// sustained rate once the window is full, and bars that yield no result pass
// at one per cycle while the queue has room. With an empty queue, a result
// passes from its bar through the sum stage, the queue entry, the divider
// load, the steps and the output state. A zero volume sum gives average 0
// with zero_volume set. No clearing pass is run after reset.
module volume_weighted_moving_average #(
	parameter int MAX_WINDOW  = 256,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          bar_valid,
	output logic                               bar_ready,
	input  wire vwma_pkg::bar_t                bar,
	output logic                               avg_valid,
	input  wire logic                          avg_ready,
	output vwma_pkg::avg_t                     avg,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vwma_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [vwma_pkg::DATA_W-1:0]   pwdata,
	output logic      [vwma_pkg::DATA_W-1:0]   prdata,
	output logic                               pready
);

	import vwma_pkg::*;

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW+1);
	localparam int PS_W  = PROD_W + AW;
	localparam int VS_W  = VOLUME_W + AW;

	logic [CFG_W-1:0]     window_q;
	logic [CNT_W-1:0]     win_len;
	logic                 restart;
	fifo_stat_t           q_stat;
	logic                 push;
	logic [PS_W-1:0]      psum;
	logic [VS_W-1:0]      vsum;
	logic                 q_valid;
	logic                 q_pop;
	logic [PS_W+VS_W-1:0] q_data;

	// register write on the access beat
	assign pready  = 1'b1;
	assign restart = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (restart) begin
			window_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? DATA_W'(window_q) : '0;

	// effective length: zero means one, clamp at the ring depth
	always_comb begin
		if (window_q == '0) begin
			win_len = CNT_W'(1);
		end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
			win_len = CNT_W'(MAX_WINDOW);
		end else begin
			win_len = CNT_W'(window_q);
		end
	end

	vwma_front #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_valid (bar_valid),
		.bar_ready (bar_ready),
		.bar       (bar),
		.win_len   (win_len),
		.restart   (restart),
		.q_stat    (q_stat),
		.push      (push),
		.psum      (psum),
		.vsum      (vsum)
	);

	vwma_fifo #(
		.WIDTH (PS_W + VS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({psum, vsum}),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_data),
		.stat   (q_stat)
	);

	vwma_divider #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.psum      (q_data[PS_W+VS_W-1:VS_W]),
		.vsum      (q_data[VS_W-1:0]),
		.q_pop     (q_pop),
		.avg_valid (avg_valid),
		.avg_ready (avg_ready),
		.avg       (avg)
	);

endmodule

`default_nettype wire

// ===== rtl/vwma_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vwma_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        avg_valid,
	input wire logic                        avg_ready,
	input wire vwma_pkg::avg_t              avg,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [vwma_pkg::ADDR_W-1:0] paddr,
	input wire logic [vwma_pkg::DATA_W-1:0] pwdata,
	input wire logic [vwma_pkg::DATA_W-1:0] prdata,
	input wire logic                        pready
);

	import vwma_pkg::*;

	// a stalled result beat holds
	a_avg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && !avg_ready |=> avg_valid && $stable(avg))
		else $error("result beat changed while stalled");

	// a zero volume sum gives a zero average
	a_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && avg.zero_volume |-> avg.average == '0)
		else $error("zero volume flag with nonzero average");

	// written window length reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LENGTH) |=>
		!(psel && !pwrite && (paddr[2] == REG_WINDOW_LENGTH)) ||
		(prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0])))
		else $error("window length readback mismatch");

	// registers outside the map read as zero
	a_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		psel && (paddr[2] != REG_WINDOW_LENGTH) |-> prdata == '0 && pready)
		else $error("unmapped register read nonzero");

endmodule

bind volume_weighted_moving_average vwma_checker u_chk (.*);

`default_nettype wire
